>>> rtl/core/bfvd_pkg.sv
// Shared types, constants and helper functions of the vertex dedup block.
package bfvd_pkg;

   localparam int TABLE_BITS   = 2097152;
   localparam int MAX_VERTICES = 65536;
   localparam int MAX_ROUNDS   = 64;

   // Bloom table is kept as rows of 64 bits.
   localparam int ROW_W      = 64;
   localparam int ROW_OW     = $clog2(ROW_W);
   localparam int TBL_AW     = $clog2(TABLE_BITS);
   localparam int BLOOM_ROWS = TABLE_BITS / ROW_W;
   localparam int ROW_AW     = $clog2(BLOOM_ROWS);
   localparam int VTX_AW     = $clog2(MAX_VERTICES);

   localparam int CNT_W   = 17;
   localparam int RND_W   = 7;
   localparam int MOD_W   = 22;
   localparam int SALT_AW = 6;

   localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;

   // Register indexes of the control port.
   localparam logic CSR_HASH_ROUNDS = 1'b0;
   localparam logic CSR_TABLE_SIZE  = 1'b1;

   typedef struct packed {
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] vertex_index;
      logic             is_new;
      logic             false_positive;
      logic             store_full;
      logic [CNT_W-1:0] vertex_total;
   } rsp_type;

   // Remainder unit handshake.
   typedef struct packed {
      logic             start;
      logic [31:0]      dividend;
      logic [MOD_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [TBL_AW-1:0] rem;
   } mod_rsp_type;

   function automatic logic [31:0] salt(input logic [SALT_AW-1:0] r);
      logic [31:0] s;
      case (r)
         6'd0:  s = 32'h1953c322;  6'd1:  s = 32'h588ccf17;
         6'd2:  s = 32'h64bf600c;  6'd3:  s = 32'ha6be3f3d;
         6'd4:  s = 32'h341a02ea;  6'd5:  s = 32'h15b03217;
         6'd6:  s = 32'h3b062858;  6'd7:  s = 32'h5956fd06;
         6'd8:  s = 32'h18b5624f;  6'd9:  s = 32'he3be0b46;
         6'd10: s = 32'h20ffcd5c;  6'd11: s = 32'ha35dfd2b;
         6'd12: s = 32'h1fc4a9bf;  6'd13: s = 32'h57c45d5c;
         6'd14: s = 32'ha8661c4a;  6'd15: s = 32'h4f1b74d2;
         6'd16: s = 32'h5a6dde13;  6'd17: s = 32'h3b18dac6;
         6'd18: s = 32'h05a8afbf;  6'd19: s = 32'hbbda2fe2;
         6'd20: s = 32'ha2520d78;  6'd21: s = 32'he7934849;
         6'd22: s = 32'hd541bc75;  6'd23: s = 32'h09a55b57;
         6'd24: s = 32'h9b345ae2;  6'd25: s = 32'hfc2d26af;
         6'd26: s = 32'h38679cef;  6'd27: s = 32'h81bd1e0d;
         6'd28: s = 32'h654681ae;  6'd29: s = 32'h4b3d87ad;
         6'd30: s = 32'hd5ff10fb;  6'd31: s = 32'h23b32f67;
         6'd32: s = 32'hafc7e366;  6'd33: s = 32'hdd955ead;
         6'd34: s = 32'he7c34b1c;  6'd35: s = 32'hfeace0a6;
         6'd36: s = 32'heb16f09d;  6'd37: s = 32'h3c57a72d;
         6'd38: s = 32'h2c8294c5;  6'd39: s = 32'hba92662a;
         6'd40: s = 32'hcd5b2d14;  6'd41: s = 32'h743936c8;
         6'd42: s = 32'h2489beff;  6'd43: s = 32'hc6c56e00;
         6'd44: s = 32'h74a4f606;  6'd45: s = 32'hb244a94a;
         6'd46: s = 32'h5edfc423;  6'd47: s = 32'hf1901934;
         6'd48: s = 32'h24af7691;  6'd49: s = 32'hf6c98b25;
         6'd50: s = 32'hea25af46;  6'd51: s = 32'h76d5f2e6;
         6'd52: s = 32'h5e33cdf2;  6'd53: s = 32'h445eb357;
         6'd54: s = 32'h88556bd2;  6'd55: s = 32'h70d1da7a;
         6'd56: s = 32'h54449368;  6'd57: s = 32'h381020bc;
         6'd58: s = 32'h1c0520bf;  6'd59: s = 32'hf7e44942;
         6'd60: s = 32'ha27e2a58;  6'd61: s = 32'h66866fc5;
         6'd62: s = 32'h12519ce7;  6'd63: s = 32'h437a8456;
         default: s = 32'h0;
      endcase
      return s;
   endfunction

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
   endfunction

   // Single-float equality: signed zeros match, NaN never matches.
   function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] o;
      o = a | b;
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (o[30:0] == 31'd0) return 1'b1;
      return a == b;
   endfunction

endpackage

>>> rtl/core/bfvd_hash.sv
// FNV-1 32-bit hash of a point, one byte per cycle.
module bfvd_hash (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bfvd_pkg::req_type point,
   output logic             done,
   output logic [31:0]      hval
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [95:0] data_ff, data_in;
   logic [31:0] h_ff, h_in;
   logic [31:0] prod;

   assign prod = 32'(h_ff * bfvd_pkg::FNV_PRIME);

   // Load x, y, z little-endian, then fold in one byte each cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      data_in = data_ff;
      h_in    = h_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         data_in = {point.z_bits, point.y_bits, point.x_bits};
         h_in    = bfvd_pkg::FNV_BASIS;
      end else if (busy_ff) begin
         h_in    = prod ^ {24'd0, data_ff[7:0]};
         data_in = {8'd0, data_ff[95:8]};
         cnt_in  = cnt_ff + 4'd1;
         if (cnt_ff == 4'd11) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      data_ff <= data_in;
      h_ff    <= h_in;
   end

   assign done = done_ff;
   assign hval = h_ff;

endmodule

>>> rtl/core/bfvd_modu.sv
// Restoring remainder unit: 32-bit dividend by table modulus, one bit per cycle.
module bfvd_modu (
   input  logic                  clock,
   input  logic                  reset,
   input  bfvd_pkg::mod_req_type req,
   output bfvd_pkg::mod_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [31:0]                dvd_ff, dvd_in;
   logic [bfvd_pkg::MOD_W-1:0] div_ff, div_in;
   logic [bfvd_pkg::MOD_W-1:0] rem_ff, rem_in;
   logic [bfvd_pkg::MOD_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[31]};

   // Shift in one dividend bit, subtract the divisor when it fits.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         dvd_in  = req.dividend;
         div_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = bfvd_pkg::MOD_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[bfvd_pkg::MOD_W-1:0];
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[bfvd_pkg::TBL_AW-1:0];

endmodule

>>> rtl/core/bloom_filtered_vertex_dedup.sv
// Top level: sequencer, bloom table, vertex store and result register.
// Steps: hashing, then per bloom probe the remainder unit plus a table read; if every
// probe hits, a search of the stored vertices (read and compare each); for a new point
// the same remainder and table step per bloom bit set; and last, store and report.
// One point at a time: the input is stalled from acceptance until the result is
// registered, while the bloom table is cleared, and while the result waits on a stall.
// Reset: synchronous; afterward all 32768 rows of the bloom table are cleared row by row.
module bloom_filtered_vertex_dedup (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bfvd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bfvd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [bfvd_pkg::MOD_W-1:0]          csr_wdata
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HASH   = 4'd2;
   localparam logic [3:0] S_MODGO  = 4'd3;
   localparam logic [3:0] S_MODW   = 4'd4;
   localparam logic [3:0] S_BREAD  = 4'd5;
   localparam logic [3:0] S_BCHK   = 4'd6;
   localparam logic [3:0] S_SREAD  = 4'd7;
   localparam logic [3:0] S_SCMP   = 4'd8;
   localparam logic [3:0] S_DECIDE = 4'd9;
   localparam logic [3:0] S_STORE  = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   localparam int CW = bfvd_pkg::CNT_W;
   localparam int RA = bfvd_pkg::ROW_AW;

   logic [3:0]                  state_ff, state_in;
   logic [RA-1:0]               clr_ff, clr_in;
   logic [bfvd_pkg::RND_W-1:0]  hash_rounds_ff, hash_rounds_in;
   logic [bfvd_pkg::MOD_W-1:0]  table_size_ff, table_size_in;
   logic [bfvd_pkg::RND_W-1:0]  rounds_ff, rounds_in;
   logic [bfvd_pkg::RND_W-1:0]  round_ff, round_in;
   logic [bfvd_pkg::MOD_W-1:0]  mod_ff, mod_in;
   bfvd_pkg::req_type           point_ff, point_in;
   logic [31:0]                 h_ff, h_in;
   logic [bfvd_pkg::TBL_AW-1:0] bit_ff, bit_in;
   logic                        setting_ff, setting_in;
   logic                        present_ff, present_in;
   logic                        found_ff, found_in;
   logic                        full_ff, full_in;
   logic                        added_ff, added_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               k_ff, k_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bfvd_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        hash_start, hash_done;
   logic [31:0]                 hash_val;
   bfvd_pkg::mod_req_type       mreq;
   bfvd_pkg::mod_rsp_type       mrsp;

   logic [bfvd_pkg::ROW_W-1:0]  bloom_mem [bfvd_pkg::BLOOM_ROWS];
   logic [bfvd_pkg::ROW_W-1:0]  bloom_rd_ff;
   logic                        bl_we;
   logic [RA-1:0]               bl_waddr;
   logic [bfvd_pkg::ROW_W-1:0]  bl_wdata;
   logic [RA-1:0]               bl_row;
   logic [bfvd_pkg::ROW_OW-1:0] bl_off;
   logic                        bl_hit;

   logic [95:0]                 vtx_mem [bfvd_pkg::MAX_VERTICES];
   logic [95:0]                 vtx_rd_ff;
   logic [CW-1:0]               k_dec;
   logic                        vtx_match;
   logic                        last_round;
   logic                        req_acc;

   assign req_acc    = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign bl_row     = bit_ff[bfvd_pkg::TBL_AW-1:bfvd_pkg::ROW_OW];
   assign bl_off     = bit_ff[bfvd_pkg::ROW_OW-1:0];
   assign bl_hit     = bloom_rd_ff[bl_off];
   assign k_dec      = k_ff - CW'(1);
   assign last_round = (round_ff + bfvd_pkg::RND_W'(1)) == rounds_ff;
   assign vtx_match  = bfvd_pkg::float_eq(vtx_rd_ff[31:0],  point_ff.x_bits) &&
                       bfvd_pkg::float_eq(vtx_rd_ff[63:32], point_ff.y_bits) &&
                       bfvd_pkg::float_eq(vtx_rd_ff[95:64], point_ff.z_bits);

   assign hash_start    = req_acc;
   assign mreq.start    = (state_ff == S_MODGO);
   assign mreq.dividend = h_ff ^ bfvd_pkg::salt(round_ff[bfvd_pkg::SALT_AW-1:0]);
   assign mreq.divisor  = mod_ff;

   bfvd_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .point (req_data),
      .done  (hash_done),
      .hval  (hash_val)
   );

   bfvd_modu u_modu (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   // Capture register writes.
   always_comb begin
      hash_rounds_in = hash_rounds_ff;
      table_size_in  = table_size_ff;
      if (csr_we) begin
         case (csr_index)
            bfvd_pkg::CSR_HASH_ROUNDS: hash_rounds_in = csr_wdata[bfvd_pkg::RND_W-1:0];
            bfvd_pkg::CSR_TABLE_SIZE:  table_size_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Bloom write port: clearing sweep or setting one bit.
   always_comb begin
      bl_we    = 1'b0;
      bl_waddr = bl_row;
      bl_wdata = bloom_rd_ff | (bfvd_pkg::ROW_W'(1) << bl_off);
      if (state_ff == S_CLEAR) begin
         bl_we    = 1'b1;
         bl_waddr = clr_ff;
         bl_wdata = '0;
      end else if (state_ff == S_BCHK && setting_ff) begin
         bl_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (bl_we) begin
         bloom_mem[bl_waddr] <= bl_wdata;
      end
      if (state_ff == S_BREAD) begin
         bloom_rd_ff <= bloom_mem[bl_row];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_STORE) begin
         vtx_mem[count_ff[bfvd_pkg::VTX_AW-1:0]] <=
            {point_ff.z_bits, point_ff.y_bits, point_ff.x_bits};
      end
      if (state_ff == S_SREAD) begin
         vtx_rd_ff <= vtx_mem[k_dec[bfvd_pkg::VTX_AW-1:0]];
      end
   end

   // Sequence: hash, probe, search, set bits, store, report.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rounds_in    = rounds_ff;
      round_in     = round_ff;
      mod_in       = mod_ff;
      point_in     = point_ff;
      h_in         = h_ff;
      bit_in       = bit_ff;
      setting_in   = setting_ff;
      present_in   = present_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      added_in     = added_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + RA'(1);
            if (clr_ff == RA'(bfvd_pkg::BLOOM_ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               point_in   = req_data;
               round_in   = '0;
               setting_in = 1'b0;
               present_in = 1'b1;
               found_in   = 1'b0;
               full_in    = 1'b0;
               added_in   = 1'b0;
               idx_in     = count_ff;
               rounds_in  = (hash_rounds_ff > bfvd_pkg::RND_W'(bfvd_pkg::MAX_ROUNDS)) ?
                            bfvd_pkg::RND_W'(bfvd_pkg::MAX_ROUNDS) : hash_rounds_ff;
               mod_in     = (table_size_ff == '0 ||
                             table_size_ff > bfvd_pkg::MOD_W'(bfvd_pkg::TABLE_BITS)) ?
                            bfvd_pkg::MOD_W'(bfvd_pkg::TABLE_BITS) : table_size_ff;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            if (hash_done) begin
               h_in = hash_val;
               k_in = count_ff;
               state_in = (rounds_ff == '0) ? S_SREAD : S_MODGO;
            end
         end
         S_MODGO: state_in = S_MODW;
         S_MODW: begin
            if (mrsp.done) begin
               bit_in   = mrsp.rem;
               state_in = S_BREAD;
            end
         end
         S_BREAD: state_in = S_BCHK;
         S_BCHK: begin
            round_in = round_ff + bfvd_pkg::RND_W'(1);
            if (setting_ff) begin
               state_in = last_round ? S_STORE : S_MODGO;
            end else if (!bl_hit) begin
               present_in = 1'b0;
               state_in   = S_DECIDE;
            end else begin
               state_in = last_round ? S_SREAD : S_MODGO;
            end
         end
         S_SREAD: begin
            if (k_ff == '0) begin
               state_in = S_DECIDE;
            end else begin
               k_in     = k_dec;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (vtx_match) begin
               found_in = 1'b1;
               idx_in   = k_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_SREAD;
            end
         end
         S_DECIDE: begin
            if (count_ff >= CW'(bfvd_pkg::MAX_VERTICES)) begin
               full_in  = 1'b1;
               state_in = S_OUT;
            end else if (rounds_ff == '0) begin
               state_in = S_STORE;
            end else begin
               round_in   = '0;
               setting_in = 1'b1;
               state_in   = S_MODGO;
            end
         end
         S_STORE: begin
            count_in = count_ff + CW'(1);
            added_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.vertex_index    = idx_ff;
               rsp_data_in.is_new          = added_ff;
               rsp_data_in.false_positive  = present_ff && !found_ff;
               rsp_data_in.store_full      = full_ff;
               rsp_data_in.vertex_total    = count_ff;
               state_in                    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         hash_rounds_ff <= bfvd_pkg::RND_W'(2);
         table_size_ff  <= bfvd_pkg::MOD_W'(bfvd_pkg::TABLE_BITS);
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         hash_rounds_ff <= hash_rounds_in;
         table_size_ff  <= table_size_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rounds_ff   <= rounds_in;
      round_ff    <= round_in;
      mod_ff      <= mod_in;
      point_ff    <= point_in;
      h_ff        <= h_in;
      bit_ff      <= bit_in;
      setting_ff  <= setting_in;
      present_ff  <= present_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      added_ff    <= added_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/bfvd_checker.sv
// Port-level checks of the vertex dedup block, bound to the top level.
module bfvd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bfvd_pkg::rsp_type rsp_data
);

   // One point at a time: after a beat in, the input is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted twice in a row");

   // A new point always grows the store by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_new |->
         rsp_data.vertex_total == bfvd_pkg::CNT_W'(rsp_data.vertex_index + 1'b1))
      else $error("new vertex index does not match total");

   // A full store never reports an insertion.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_full |->
         !rsp_data.is_new && rsp_data.vertex_index == rsp_data.vertex_total)
      else $error("store full result inconsistent");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind bloom_filtered_vertex_dedup bfvd_checker u_bfvd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
